>>> rtl/core/prl_pkg.sv
package prl_pkg;

   // Default depth of the flow table.
   localparam int DEFAULT_TABLE_ENTRIES = 64;

   // Field widths of the channels and registers.
   localparam int KIND_W      = 16;
   localparam int ADDR_W      = 32;
   localparam int LENGTH_W    = 16;
   localparam int SECONDS_W   = 32;
   localparam int PACKETS_W   = 32;
   localparam int BYTES_W     = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;

   // Ethertypes that are let into the limiter.
   localparam logic [KIND_W-1:0] KIND_IPV4 = 16'h0800;
   localparam logic [KIND_W-1:0] KIND_VLAN = 16'h8100;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PACKET_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT   = 2'd1;

   // Result codes of one item.
   typedef enum logic [1:0] {
      VERDICT_FORWARD = 2'd0,
      VERDICT_DISCARD = 2'd1,
      VERDICT_DROP    = 2'd2
   } verdict_type;

   // Counting record of one flow, kept in the record memory.
   typedef struct packed {
      logic [PACKETS_W-1:0] packets;
      logic [BYTES_W-1:0]   bytes;
      logic [SECONDS_W-1:0] window_start;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

endpackage

>>> rtl/core/prl_req_if.sv
interface prl_req_if;
   import prl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    ether_kind;
   logic [ADDR_W-1:0]    source_address;
   logic [LENGTH_W-1:0]  packet_length;
   logic [SECONDS_W-1:0] now_seconds;

   modport source (output valid, ether_kind, source_address, packet_length, now_seconds,
                   input ready);
   modport sink   (input valid, ether_kind, source_address, packet_length, now_seconds,
                   output ready);
endinterface

>>> rtl/core/prl_rsp_if.sv
interface prl_rsp_if;
   import prl_pkg::*;

   logic        valid;
   logic        ready;
   verdict_type verdict;
   logic        was_known;

   modport source (output valid, verdict, was_known, input ready);
   modport sink   (input valid, verdict, was_known, output ready);
endinterface

>>> rtl/core/prl_ram.sv
module prl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/prl_update.sv
module prl_update (
   input  logic                             clock,
   input  logic                             load,
   input  prl_pkg::rec_type                 rec_in,
   input  logic [prl_pkg::LENGTH_W-1:0]     packet_length,
   input  logic [prl_pkg::SECONDS_W-1:0]    now_seconds,
   input  logic [prl_pkg::PACKETS_W-1:0]    packet_limit,
   input  logic [prl_pkg::BYTES_W-1:0]      byte_limit,
   output prl_pkg::rec_type                 rec_out,
   output logic                             drop
);
   import prl_pkg::*;

   logic [SECONDS_W-1:0] elapsed;
   logic [BYTES_W:0]     byte_sum;
   logic                 restart_ff;
   logic [PACKETS_W-1:0] packets_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [SECONDS_W-1:0] start_ff;
   logic [SECONDS_W-1:0] now_ff;

   // First step: window test, saturating packet increment and byte add.
   assign elapsed  = now_seconds - rec_in.window_start;
   assign byte_sum = {1'b0, rec_in.bytes} + (BYTES_W + 1)'(packet_length);

   always_ff @(posedge clock) begin
      if (load) begin
         restart_ff <= (elapsed > SECONDS_W'(1));
         packets_ff <= (&rec_in.packets) ? rec_in.packets
                                         : rec_in.packets + PACKETS_W'(1);
         bytes_ff   <= byte_sum[BYTES_W] ? {BYTES_W{1'b1}} : byte_sum[BYTES_W-1:0];
         start_ff   <= rec_in.window_start;
         now_ff     <= now_seconds;
      end
   end

   // Second step: a new window clears the counts, otherwise the limits are checked.
   always_comb begin
      if (restart_ff) begin
         rec_out.packets      = '0;
         rec_out.bytes        = '0;
         rec_out.window_start = now_ff;
         drop                 = 1'b0;
      end else begin
         rec_out.packets      = packets_ff;
         rec_out.bytes        = bytes_ff;
         rec_out.window_start = start_ff;
         drop = ((packet_limit != '0) && (packets_ff >= packet_limit)) ||
                ((byte_limit != '0) && (bytes_ff >= byte_limit));
      end
   end

endmodule

>>> rtl/core/per_source_packet_rate_limiter.sv
// Per-source packet rate limiter; a flow's window restarts after more than one second.
//
// req_if carries one packet item: ethertype, IPv4 source, length and the time
// in seconds. rsp_if returns one item per packet: a verdict (forward, discard
// or drop) and whether the source was already known. Both channels move an
// item when valid and ready are high at a rising clock edge. The user is to write
// the limits via the csr_ port only while no packet is in flight; not enforced.
//
// req_if.ready is high only while the sequencer is idle. A packet that is not
// IPv4 or VLAN goes straight to its result. For any other packet a compare
// unit walks the key memory one entry a cycle to find the flow and the oldest
// entry; a hit then reads, updates and writes back its record, a miss writes a
// new entry, and a second walk over the age memory updates the recency ranks.
// The next packet can be taken in the cycle after a result is loaded.
//
// Reset empties the table at once through the fill count; there is no
// clearing pass. A finished result waits in the output register while the
// next packet is taken in; a packet that finishes while that register is
// still full waits until the receiver takes the older result.
module per_source_packet_rate_limiter #(
   parameter int TABLE_ENTRIES = prl_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   prl_req_if.sink                            req_if,
   prl_rsp_if.source                          rsp_if,
   input  logic                               csr_write_enable,
   input  logic [prl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prl_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import prl_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);
   localparam logic [AW-1:0] LAST_AGE  = AW'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_REC_RD,
      S_REC_UPD,
      S_REC_WR,
      S_INSERT,
      S_AGE,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        limit_ff, limit_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_idx_ff, pend_idx_in;
   logic                 hit_ff, hit_in;
   logic [AW-1:0]        hit_slot_ff, hit_slot_in;
   logic [AW-1:0]        lru_slot_ff, lru_slot_in;
   logic [AW-1:0]        victim_ff, victim_in;
   logic [AW-1:0]        target_ff, target_in;
   logic [CW-1:0]        thr_ff, thr_in;
   logic [ADDR_W-1:0]    src_ff, src_in;
   logic [LENGTH_W-1:0]  len_ff, len_in;
   logic [SECONDS_W-1:0] now_ff, now_in;
   verdict_type          verdict_ff, verdict_in;
   logic                 known_ff, known_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   verdict_type          rsp_verdict_ff, rsp_verdict_in;
   logic                 rsp_known_ff, rsp_known_in;
   logic [PACKETS_W-1:0] packet_limit_ff, packet_limit_in;
   logic [BYTES_W-1:0]   byte_limit_ff, byte_limit_in;

   logic [ADDR_W-1:0]    key_rd;
   logic [AW-1:0]        age_rd;
   logic [REC_W-1:0]     rec_rd_bits;
   rec_type              rec_rd;
   rec_type              upd_rec;
   logic                 upd_drop;
   logic                 key_we;
   logic                 rec_we;
   rec_type              rec_wdata;
   logic [AW-1:0]        rec_waddr;
   logic                 age_we;
   logic [AW-1:0]        age_waddr;
   logic [AW-1:0]        age_wdata;
   logic                 kind_ok;
   logic                 table_full;
   logic                 walk_done;

   // Flow table memories: keys, counting records and recency ranks.
   prl_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (victim_ff),
      .wr_data (src_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (key_rd)
   );

   prl_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (hit_slot_ff),
      .rd_data (rec_rd_bits)
   );

   prl_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (age_rd)
   );

   assign rec_rd = rec_type'(rec_rd_bits);

   // Window and limit arithmetic for a flow that hits.
   prl_update u_update (
      .clock         (clock),
      .load          (state_ff == S_REC_UPD),
      .rec_in        (rec_rd),
      .packet_length (len_ff),
      .now_seconds   (now_ff),
      .packet_limit  (packet_limit_ff),
      .byte_limit    (byte_limit_ff),
      .rec_out       (upd_rec),
      .drop          (upd_drop)
   );

   // Memory write controls.
   assign key_we    = (state_ff == S_INSERT);
   assign rec_we    = (state_ff == S_INSERT) || (state_ff == S_REC_WR);
   assign rec_waddr = (state_ff == S_INSERT) ? victim_ff : hit_slot_ff;

   always_comb begin
      if (state_ff == S_INSERT) begin
         rec_wdata.packets      = PACKETS_W'(1);
         rec_wdata.bytes        = BYTES_W'(len_ff);
         rec_wdata.window_start = now_ff;
      end else begin
         rec_wdata = upd_rec;
      end
   end

   // Rank update: the touched entry becomes the most recent, younger ones age.
   assign age_we    = (state_ff == S_INSERT) || ((state_ff == S_AGE) && pend_ff);
   assign age_waddr = (state_ff == S_INSERT) ? victim_ff : pend_idx_ff;

   always_comb begin
      if ((state_ff == S_INSERT) || (pend_idx_ff == target_ff)) begin
         age_wdata = '0;
      end else if (CW'(age_rd) < thr_ff) begin
         age_wdata = age_rd + AW'(1);
      end else begin
         age_wdata = age_rd;
      end
   end

   assign kind_ok    = (req_if.ether_kind == KIND_IPV4) || (req_if.ether_kind == KIND_VLAN);
   assign table_full = (count_ff == ENTRIES_C);
   assign walk_done  = (idx_ff == limit_ff) && !pend_ff;

   assign req_if.ready     = (state_ff == S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.verdict   = rsp_verdict_ff;
   assign rsp_if.was_known = rsp_known_ff;

   // Sequencer next state.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      limit_in        = limit_ff;
      idx_in          = idx_ff;
      pend_in         = pend_ff;
      pend_idx_in     = pend_idx_ff;
      hit_in          = hit_ff;
      hit_slot_in     = hit_slot_ff;
      lru_slot_in     = lru_slot_ff;
      victim_in       = victim_ff;
      target_in       = target_ff;
      thr_in          = thr_ff;
      src_in          = src_ff;
      len_in          = len_ff;
      now_in          = now_ff;
      verdict_in      = verdict_ff;
      known_in        = known_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_known_in    = rsp_known_ff;
      packet_limit_in = packet_limit_ff;
      byte_limit_in   = byte_limit_ff;

      // Configuration writes.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PACKET_LIMIT: packet_limit_in = csr_write_data[PACKETS_W-1:0];
            CSR_BYTE_LIMIT:   byte_limit_in   = csr_write_data[BYTES_W-1:0];
            default:          ;
         endcase
      end

      // The receiver takes the waiting result.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               src_in   = req_if.source_address;
               len_in   = req_if.packet_length;
               now_in   = req_if.now_seconds;
               limit_in = count_ff;
               idx_in   = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               if (kind_ok) begin
                  state_in = S_SCAN;
               end else begin
                  verdict_in = VERDICT_DISCARD;
                  known_in   = 1'b0;
                  state_in   = S_DONE;
               end
            end
         end

         S_SCAN: begin
            // Issue one key read a cycle and compare the one read before.
            if (idx_ff != limit_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
               idx_in      = idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (key_rd == src_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = pend_idx_ff;
                  thr_in      = CW'(age_rd);
                  target_in   = pend_idx_ff;
               end
               if (age_rd == LAST_AGE) begin
                  lru_slot_in = pend_idx_ff;
               end
            end
            if (walk_done) begin
               if (hit_ff) begin
                  state_in = S_REC_RD;
               end else if (table_full) begin
                  victim_in = lru_slot_ff;
                  target_in = lru_slot_ff;
                  thr_in    = CW'(LAST_AGE);
                  state_in  = S_INSERT;
               end else begin
                  victim_in = count_ff[AW-1:0];
                  target_in = count_ff[AW-1:0];
                  thr_in    = ENTRIES_C;
                  state_in  = S_INSERT;
               end
            end
         end

         S_REC_RD: begin
            state_in = S_REC_UPD;
         end

         S_REC_UPD: begin
            state_in = S_REC_WR;
         end

         S_REC_WR: begin
            verdict_in = upd_drop ? VERDICT_DROP : VERDICT_FORWARD;
            known_in   = 1'b1;
            idx_in     = '0;
            pend_in    = 1'b0;
            state_in   = S_AGE;
         end

         S_INSERT: begin
            if (!table_full) begin
               count_in = count_ff + CW'(1);
            end
            verdict_in = VERDICT_FORWARD;
            known_in   = 1'b0;
            idx_in     = '0;
            pend_in    = 1'b0;
            state_in   = S_AGE;
         end

         S_AGE: begin
            // Read one rank a cycle; the rank read before is written back.
            if (idx_ff != limit_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
               idx_in      = idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (walk_done) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_known_in   = known_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         pend_ff         <= 1'b0;
         hit_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         packet_limit_ff <= '0;
         byte_limit_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         pend_ff         <= pend_in;
         hit_ff          <= hit_in;
         rsp_valid_ff    <= rsp_valid_in;
         packet_limit_ff <= packet_limit_in;
         byte_limit_ff   <= byte_limit_in;
      end
      limit_ff       <= limit_in;
      idx_ff         <= idx_in;
      pend_idx_ff    <= pend_idx_in;
      hit_slot_ff    <= hit_slot_in;
      lru_slot_ff    <= lru_slot_in;
      victim_ff      <= victim_in;
      target_ff      <= target_in;
      thr_ff         <= thr_in;
      src_ff         <= src_in;
      len_ff         <= len_in;
      now_ff         <= now_in;
      verdict_ff     <= verdict_in;
      known_ff       <= known_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_known_ff   <= rsp_known_in;
   end

endmodule

>>> rtl/core/prl_checker.sv
module prl_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input prl_pkg::verdict_type rsp_verdict,
   input logic                 rsp_was_known
);
   import prl_pkg::*;

   // A waiting result stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // A waiting result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_verdict) && $stable(rsp_was_known))
      else $error("result payload changed while stalled");

   // A discarded packet (neither IPv4 nor VLAN) never reports a known source.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_DISCARD) |-> !rsp_was_known)
      else $error("discarded item reports a known source");

   // Only a flow already in the table can be over its limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_DROP) |-> rsp_was_known)
      else $error("rate drop on an unknown source");

   // The block takes no new item while it works on one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while the previous one is in progress");

endmodule

bind per_source_packet_rate_limiter prl_checker u_prl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_verdict   (rsp_if.verdict),
   .rsp_was_known (rsp_if.was_known)
);

>>> sim/prl_verdict_checker.sv
module prl_verdict_checker #(
   parameter int ENTRIES = prl_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   prl_req_if                              req_mon,
   prl_rsp_if                              rsp_mon,
   input  logic                            csr_write_enable,
   input  logic [prl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prl_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned                     failures,
   output int unsigned                     pending,
   output int unsigned                     checked,
   output int unsigned                     forwarded,
   output int unsigned                     discarded,
   output int unsigned                     dropped,
   output int unsigned                     evicted
);
   import prl_pkg::*;

   localparam int RANK_W = $clog2(ENTRIES);

   // Verdict and known-source flag that one packet item should produce.
   typedef struct packed {
      verdict_type verdict;
      logic        was_known;
   } outcome_type;

   // Own copy of the limits and of the flow table.
   logic [PACKETS_W-1:0] packet_limit;
   logic [BYTES_W-1:0]   byte_limit;
   bit                   flow_valid [ENTRIES];
   logic [ADDR_W-1:0]    flow_key [ENTRIES];
   logic [PACKETS_W-1:0] flow_packets [ENTRIES];
   logic [BYTES_W-1:0]   flow_bytes [ENTRIES];
   logic [SECONDS_W-1:0] flow_start [ENTRIES];
   logic [RANK_W-1:0]    flow_rank [ENTRIES];

   outcome_type outcomes_due [$];
   outcome_type head;
   outcome_type want;

   // Print one line for a mismatch and count it.
   task report_mismatch(input string what);
      failures++;
      $display("[%0t] verdict check: %s", $time, what);
   endtask

   // Make a slot the most recent; every valid flow more recent than it ages by one.
   task promote_flow(input int slot);
      logic [RANK_W-1:0] old_rank;
      old_rank = flow_rank[slot];
      for (int j = 0; j < ENTRIES; j++) begin
         if (j != slot && flow_valid[j] && flow_rank[j] < old_rank) begin
            flow_rank[j]++;
         end
      end
      flow_rank[slot] = '0;
   endtask

   // Work out the outcome of one packet and update the flow table.
   task judge_packet(
      input  logic [KIND_W-1:0]    kind,
      input  logic [ADDR_W-1:0]    source,
      input  logic [LENGTH_W-1:0]  length,
      input  logic [SECONDS_W-1:0] seconds,
      output outcome_type          outcome
   );
      int                   slot;
      int                   victim;
      logic [SECONDS_W-1:0] elapsed;
      logic [BYTES_W:0]     byte_sum;
      outcome.verdict   = VERDICT_FORWARD;
      outcome.was_known = 1'b0;
      slot   = -1;
      victim = -1;
      if (kind != KIND_IPV4 && kind != KIND_VLAN) begin
         outcome.verdict = VERDICT_DISCARD;
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && flow_valid[i] && flow_key[i] == source) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            // Known flow: either a fresh window or counting inside the current one.
            outcome.was_known = 1'b1;
            elapsed = seconds - flow_start[slot];
            if (elapsed > 1) begin
               flow_packets[slot] = '0;
               flow_bytes[slot]   = '0;
               flow_start[slot]   = seconds;
            end else begin
               byte_sum = {1'b0, flow_bytes[slot]} + (BYTES_W + 1)'(length);
               if (flow_packets[slot] != {PACKETS_W{1'b1}}) begin
                  flow_packets[slot]++;
               end
               flow_bytes[slot] = byte_sum[BYTES_W] ? {BYTES_W{1'b1}} : byte_sum[BYTES_W-1:0];
               if ((packet_limit != 0 && flow_packets[slot] >= packet_limit) ||
                   (byte_limit != 0 && flow_bytes[slot] >= byte_limit)) begin
                  outcome.verdict = VERDICT_DROP;
               end
            end
            promote_flow(slot);
         end else begin
            // New flow: lowest free slot, or else the least recently used one.
            for (int i = 0; i < ENTRIES; i++) begin
               if (victim < 0 && !flow_valid[i]) begin
                  victim = i;
               end
            end
            if (victim >= 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (flow_valid[i]) begin
                     flow_rank[i]++;
                  end
               end
               flow_valid[victim] = 1'b1;
               flow_rank[victim]  = '0;
            end else begin
               victim = 0;
               for (int i = 1; i < ENTRIES; i++) begin
                  if (flow_rank[i] > flow_rank[victim]) begin
                     victim = i;
                  end
               end
               promote_flow(victim);
               evicted++;
            end
            flow_key[victim]     = source;
            flow_packets[victim] = PACKETS_W'(1);
            flow_bytes[victim]   = BYTES_W'(length);
            flow_start[victim]   = seconds;
         end
      end
   endtask

   // Follow the register writes, compare each result item, then predict each new packet.
   always @(posedge clock) begin
      if (reset) begin
         packet_limit = '0;
         byte_limit   = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            flow_valid[i] = 1'b0;
         end
         outcomes_due.delete();
         failures  = 0;
         checked   = 0;
         forwarded = 0;
         discarded = 0;
         dropped   = 0;
         evicted   = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PACKET_LIMIT: packet_limit = csr_write_data[PACKETS_W-1:0];
               CSR_BYTE_LIMIT:   byte_limit = csr_write_data[BYTES_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, verdict %0d known %0d",
                                         rsp_mon.verdict, rsp_mon.was_known));
            end else begin
               head = outcomes_due.pop_front();
               checked++;
               if (rsp_mon.verdict !== head.verdict) begin
                  report_mismatch($sformatf("result %0d: verdict %0d, expected %0d",
                                            checked, rsp_mon.verdict, head.verdict));
               end
               if (rsp_mon.was_known !== head.was_known) begin
                  report_mismatch($sformatf("result %0d: was_known %0d, expected %0d",
                                            checked, rsp_mon.was_known, head.was_known));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            judge_packet(req_mon.ether_kind, req_mon.source_address, req_mon.packet_length,
                         req_mon.now_seconds, want);
            outcomes_due.push_back(want);
            case (want.verdict)
               VERDICT_FORWARD: forwarded++;
               VERDICT_DISCARD: discarded++;
               default:         dropped++;
            endcase
         end
      end
      pending <= outcomes_due.size();
   end

endmodule

>>> sim/testbench.sv
module testbench;
   import prl_pkg::*;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 150;
   localparam int PHASE_ITEMS      = 125;
   localparam int PHASE_COUNT      = 6;

   // Indexes past the two registers; writes to them must leave the limits alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   prl_req_if req_ch ();
   prl_rsp_if rsp_ch ();

   int unsigned failures;
   int unsigned pending;
   int unsigned checked;
   int unsigned forwarded;
   int unsigned discarded;
   int unsigned dropped;
   int unsigned evicted;

   int unsigned cycle_count = 0;
   int unsigned packets_sent = 0;
   int unsigned settings_used = 0;
   int unsigned long_holds = 0;
   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;

   // Source addresses of the current phase; the first four are the busiest flows.
   logic [ADDR_W-1:0]    flow_pool [128];
   int                   pool_size = 4;
   logic [SECONDS_W-1:0] wall_seconds = '0;

   per_source_packet_rate_limiter #(
      .TABLE_ENTRIES(DEFAULT_TABLE_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   prl_verdict_checker #(
      .ENTRIES(DEFAULT_TABLE_ENTRIES)
   ) verdict_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .failures        (failures),
      .pending         (pending),
      .checked         (checked),
      .forwarded       (forwarded),
      .discarded       (discarded),
      .dropped         (dropped),
      .evicted         (evicted)
   );

   always #5 clock = ~clock;

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("per_source_packet_rate_limiter verification failed");
         $finish;
      end
   end

   // Offer one packet item, after an optional gap, and wait until it is taken.
   task send_packet(
      input logic [KIND_W-1:0]    kind,
      input logic [ADDR_W-1:0]    source,
      input logic [LENGTH_W-1:0]  length,
      input logic [SECONDS_W-1:0] seconds
   );
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.ether_kind     <= kind;
      req_ch.source_address <= source;
      req_ch.packet_length  <= length;
      req_ch.now_seconds    <= seconds;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      packets_sent++;
   endtask

   // Stop offering and wait until every expected result item has come back.
   task wait_for_results;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; the caller lowers the enable after its last write.
   task write_register(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task write_limits(input logic [PACKETS_W-1:0] packets, input logic [BYTES_W-1:0] bytes);
      write_register(CSR_PACKET_LIMIT, {{(CSR_DATA_W-PACKETS_W){1'b0}}, packets});
      write_register(CSR_BYTE_LIMIT, bytes);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Mostly well-formed packets from the phase's flows, with some noise kinds and new sources.
   task random_packet;
      logic [KIND_W-1:0]   kind;
      logic [ADDR_W-1:0]   source;
      logic [LENGTH_W-1:0] length;
      int                  roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         kind = KIND_W'($urandom);
      end else if (roll < 11) begin
         kind = KIND_IPV4 ^ (16'h0001 << $urandom_range(0, 15));
      end else if (roll < 13) begin
         kind = KIND_VLAN ^ (16'h0001 << $urandom_range(0, 15));
      end else begin
         kind = ($urandom_range(0, 1) != 0) ? KIND_IPV4 : KIND_VLAN;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         source = flow_pool[$urandom_range(0, 3)];
      end else if (roll < 90) begin
         source = flow_pool[$urandom_range(0, pool_size - 1)];
      end else begin
         source = $urandom;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         length = LENGTH_W'($urandom_range(40, 1500));
      end else if (roll < 90) begin
         length = LENGTH_W'($urandom_range(0, 65535));
      end else if (roll < 95) begin
         length = '0;
      end else begin
         length = '1;
      end
      // Time mostly stands still or ticks by one, now and then jumping.
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
         wall_seconds = wall_seconds;
      end else if (roll < 97) begin
         wall_seconds = wall_seconds + 1;
      end else if (roll < 99) begin
         wall_seconds = wall_seconds + $urandom_range(2, 6);
      end else begin
         wall_seconds = $urandom;
      end
      send_packet(kind, source, length, wall_seconds);
   endtask

   // Result side: ready in runs, short random stalls, and one long hold on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            long_holds++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Stimulus: directed packets first, then random phases under changing limits.
   initial begin
      int                   phase;
      int                   n;
      logic [PACKETS_W-1:0] packet_cap;
      logic [BYTES_W-1:0]   byte_cap;
      req_ch.valid          <= 1'b0;
      req_ch.ether_kind     <= '0;
      req_ch.source_address <= '0;
      req_ch.packet_length  <= '0;
      req_ch.now_seconds    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Kinds that are not let in, with every field at its extremes.
      send_packet(16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);
      send_packet(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_packet(KIND_IPV4 ^ 16'h0001, 32'h0000_0000, 16'h0000, 32'h0000_0000);
      send_packet(KIND_VLAN ^ 16'h8000, 32'h0000_0000, 16'h0000, 32'h0000_0000);
      // New flows, a hit inside the window, a hit across the time wrap, a window restart.
      send_packet(KIND_IPV4, 32'h0000_0000, 16'h0000, 32'h0000_0000);
      send_packet(KIND_VLAN, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_packet(KIND_IPV4, 32'h0000_0000, 16'hFFFF, 32'h0000_0001);
      send_packet(KIND_VLAN, 32'hFFFF_FFFF, 16'h0001, 32'h0000_0000);
      send_packet(KIND_IPV4, 32'h0000_0000, 16'h0040, 32'h0000_0002);
      send_packet(16'h0000, 32'hFFFF_FFFF, 16'h0040, 32'h0000_0002);

      // Packet limit reached, then kept drop by drop.
      wait_for_results();
      write_limits(32'd2, 40'd0);
      send_packet(KIND_IPV4, 32'h0A00_0001, 16'd64, 32'd100);
      send_packet(KIND_IPV4, 32'h0A00_0001, 16'd64, 32'd100);
      send_packet(KIND_VLAN, 32'h0A00_0001, 16'd64, 32'd101);
      send_packet(KIND_IPV4, 32'h0A00_0001, 16'd64, 32'd104);

      // Byte limit reached exactly.
      wait_for_results();
      write_limits(32'd0, 40'd1000);
      send_packet(KIND_IPV4, 32'h0A00_0002, 16'd600, 32'd200);
      send_packet(KIND_IPV4, 32'h0A00_0002, 16'd400, 32'd200);

      // Smallest packet limit with the largest byte limit, then writes to unused indexes.
      wait_for_results();
      write_limits(32'd1, {BYTES_W{1'b1}});
      send_packet(KIND_VLAN, 32'h0A00_0003, 16'd100, 32'd300);
      send_packet(KIND_VLAN, 32'h0A00_0003, 16'd100, 32'd300);
      wait_for_results();
      write_register(CSR_SPARE_2, {CSR_DATA_W{1'b1}});
      write_register(CSR_SPARE_3, 40'h00_0000_0000);
      csr_write_enable <= 1'b0;
      send_packet(KIND_IPV4, 32'h0A00_0003, 16'd100, 32'd301);

      // Largest limits: counting goes on without drops.
      wait_for_results();
      write_limits({PACKETS_W{1'b1}}, {BYTES_W{1'b1}});
      send_packet(KIND_IPV4, 32'h0A00_0003, 16'hFFFF, 32'd301);

      // Random phases; each starts from an idle block with new limits and flows.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               packet_cap = '0;
               byte_cap   = '0;
               pool_size  = 12;
            end
            1: begin
               packet_cap = 32'd3;
               byte_cap   = '0;
               pool_size  = 20;
            end
            2: begin
               packet_cap = '0;
               byte_cap   = BYTES_W'($urandom_range(20000, 300000));
               pool_size  = 30;
            end
            3: begin
               packet_cap = 32'd5;
               byte_cap   = 40'd200000;
               pool_size  = 90;
            end
            4: begin
               packet_cap = {PACKETS_W{1'b1}};
               byte_cap   = {BYTES_W{1'b1}};
               pool_size  = 70;
            end
            default: begin
               packet_cap = 32'd1;
               byte_cap   = 40'd1;
               pool_size  = 16;
            end
         endcase
         wait_for_results();
         write_limits(packet_cap, byte_cap);
         for (int i = 0; i < pool_size; i++) begin
            flow_pool[i] = $urandom;
         end
         wall_seconds = (phase == 3) ? 32'hFFFF_FFF0 : $urandom;
         if (phase == PHASE_COUNT - 1) begin
            idle_on = 1'b0;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 40) begin
               hold_request = 1'b1;
            end
            random_packet();
         end
      end

      // Drain, let the block settle, then give the verdict.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d packets under %0d limit settings; %0d results compared.",
               packets_sent, settings_used, checked);
      $display("Outcomes: %0d forwarded, %0d discarded, %0d dropped, %0d flows evicted, %s",
               forwarded, discarded, dropped, evicted,
               $sformatf("%0d long holds.", long_holds));
      if (failures == 0) begin
         $display("per_source_packet_rate_limiter verification clean");
      end else begin
         $display("per_source_packet_rate_limiter verification failed");
      end
      $finish;
   end

endmodule
